### sv/cvd_pkg.sv
// cvd_pkg: shared types and constants of the count vector downscaler
// no dependencies
package cvd_pkg;

  localparam int unsigned LANES = 6;
  localparam int unsigned NUC   = 4;

  // ranking and threshold flags carried alongside the divider lanes
  typedef struct packed {
    logic       scaled;
    logic [1:0] ord0;
    logic [1:0] ord1;
    logic [1:0] ord2;
    logic       gt34;
    logic       gt12;
    logic       gt56a;
    logic       gt56b;
  } ctl_t;

endpackage

### sv/cvd_front.sv
// cvd_front: sum, products, ranking and fraction thresholds (three stages)
// depends on cvd_pkg
module cvd_front #(
  parameter int unsigned W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              v_i,
  input  logic [W-1:0]      cnt_i [cvd_pkg::LANES],
  input  logic [W-1:0]      lim_i,
  output logic              v_o,
  output logic [W+1:0]      rem_o [cvd_pkg::LANES],
  output logic [W-1:0]      lo_o  [cvd_pkg::LANES],
  output logic [W+1:0]      sum_o,
  output logic [W-1:0]      lim_o,
  output logic [W-1:0]      raw_o [cvd_pkg::LANES],
  output cvd_pkg::ctl_t     ctl_o
);

  localparam int unsigned CW = W + 6;
  localparam int unsigned H  = W / 2;

  logic              v1_q, v2_q, v3_q;
  logic [W-1:0]      c1_q [cvd_pkg::LANES];
  logic [W-1:0]      c2_q [cvd_pkg::LANES];
  logic [W-1:0]      c3_q [cvd_pkg::LANES];
  logic [W+1:0]      sum1_q, sum2_q, sum3_q;
  logic [W-1:0]      lim1_q, lim2_q, lim3_q;
  logic [W+H-1:0]    pplo2_q [cvd_pkg::LANES];
  logic [2*W-H-1:0]  pphi2_q [cvd_pkg::LANES];
  logic [2*W-1:0]    prod3_q [cvd_pkg::LANES];
  logic [W+1:0]      sum_d;
  cvd_pkg::ctl_t     ctl2_d, ctl2_q, ctl3_d, ctl3_q;

  assign sum_d = {2'b00, cnt_i[0]} + {2'b00, cnt_i[1]} + {2'b00, cnt_i[2]} + {2'b00, cnt_i[3]};

  // stable descending rank, ties to lower index
  always_comb begin
    logic [1:0] rank [cvd_pkg::NUC];
    logic       beat;
    ctl2_d = '0;
    for (int i = 0; i < 4; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < 4; j++) begin
        beat = (c1_q[j] > c1_q[i]) || ((c1_q[j] == c1_q[i]) && (j < i));
        if (beat) rank[i] = rank[i] + 2'd1;
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (rank[i] == 2'd0) ctl2_d.ord0 = 2'(i);
      if (rank[i] == 2'd1) ctl2_d.ord1 = 2'(i);
      if (rank[i] == 2'd2) ctl2_d.ord2 = 2'(i);
    end
    ctl2_d.scaled = sum1_q > {2'b00, lim1_q};
  end

  always_comb begin
    logic [CW-1:0] c0, c1, s;
    c0 = CW'(c2_q[ctl2_q.ord0]);
    c1 = CW'(c2_q[ctl2_q.ord1]);
    s  = CW'(sum2_q);
    ctl3_d       = ctl2_q;
    ctl3_d.gt34  = (c0 * CW'(4)) > (s * CW'(3));
    ctl3_d.gt12  = (c0 * CW'(2)) > s;
    ctl3_d.gt56a = (c0 * CW'(6)) > (s * CW'(5));
    ctl3_d.gt56b = ((c0 + c1) * CW'(6)) > (s * CW'(5));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // product split over two stages: partial products, then their sum
  always_ff @(posedge clk_i) begin
    c1_q   <= cnt_i;
    sum1_q <= sum_d;
    lim1_q <= lim_i;
    for (int i = 0; i < cvd_pkg::LANES; i++) begin
      pplo2_q[i] <= (W+H)'(c1_q[i]) * (W+H)'(lim1_q[H-1:0]);
      pphi2_q[i] <= (2*W-H)'(c1_q[i]) * (2*W-H)'(lim1_q[W-1:H]);
    end
    c2_q   <= c1_q;
    sum2_q <= sum1_q;
    lim2_q <= lim1_q;
    ctl2_q <= ctl2_d;
    for (int i = 0; i < cvd_pkg::LANES; i++) begin
      prod3_q[i] <= (2*W)'(pplo2_q[i]) + ((2*W)'(pphi2_q[i]) << H);
    end
    c3_q    <= c2_q;
    sum3_q  <= sum2_q;
    lim3_q  <= lim2_q;
    ctl3_q  <= ctl3_d;
  end

  always_comb begin
    for (int i = 0; i < cvd_pkg::LANES; i++) begin
      rem_o[i] = {2'b00, prod3_q[i][2*W-1:W]};
      lo_o[i]  = prod3_q[i][W-1:0];
    end
  end

  assign v_o   = v3_q;
  assign sum_o = sum3_q;
  assign lim_o = lim3_q;
  assign raw_o = c3_q;
  assign ctl_o = ctl3_q;

endmodule

### sv/cvd_div_stage.sv
// cvd_div_stage: one restoring division step for all six lanes
// depends on cvd_pkg
module cvd_div_stage #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           v_i,
  input  logic [W+1:0]   rem_i [cvd_pkg::LANES],
  input  logic [W-1:0]   lo_i  [cvd_pkg::LANES],
  input  logic [W+1:0]   sum_i,
  input  logic [W-1:0]   lim_i,
  input  logic [W-1:0]   raw_i [cvd_pkg::LANES],
  input  cvd_pkg::ctl_t  ctl_i,
  output logic           v_o,
  output logic [W+1:0]   rem_o [cvd_pkg::LANES],
  output logic [W-1:0]   lo_o  [cvd_pkg::LANES],
  output logic [W+1:0]   sum_o,
  output logic [W-1:0]   lim_o,
  output logic [W-1:0]   raw_o [cvd_pkg::LANES],
  output cvd_pkg::ctl_t  ctl_o
);

  logic          v_q;
  logic [W+1:0]  rem_d [cvd_pkg::LANES];
  logic [W-1:0]  lo_d  [cvd_pkg::LANES];
  logic [W+1:0]  rem_q [cvd_pkg::LANES];
  logic [W-1:0]  lo_q  [cvd_pkg::LANES];
  logic [W+1:0]  sum_q;
  logic [W-1:0]  lim_q;
  logic [W-1:0]  raw_q [cvd_pkg::LANES];
  cvd_pkg::ctl_t ctl_q;

  always_comb begin
    logic [W+2:0] t;
    logic         ge;
    for (int i = 0; i < cvd_pkg::LANES; i++) begin
      t        = {rem_i[i], lo_i[i][W-1]};
      ge       = t >= {1'b0, sum_i};
      rem_d[i] = ge ? (W+2)'(t - {1'b0, sum_i}) : t[W+1:0];
      lo_d[i]  = {lo_i[i][W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    sum_q <= sum_i;
    lim_q <= lim_i;
    raw_q <= raw_i;
    ctl_q <= ctl_i;
  end

  assign v_o   = v_q;
  assign rem_o = rem_q;
  assign lo_o  = lo_q;
  assign sum_o = sum_q;
  assign lim_o = lim_q;
  assign raw_o = raw_q;
  assign ctl_o = ctl_q;

endmodule

### sv/cvd_finish.sv
// cvd_finish: leftover units by rank and output register (two stages)
// depends on cvd_pkg
module cvd_finish #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           v_i,
  input  logic [W-1:0]   q_i   [cvd_pkg::LANES],
  input  logic [W-1:0]   lim_i,
  input  logic [W-1:0]   raw_i [cvd_pkg::LANES],
  input  cvd_pkg::ctl_t  ctl_i,
  output logic           v_o,
  output logic [W-1:0]   out_o [cvd_pkg::LANES],
  output logic           scaled_o,
  output logic [W-1:0]   lim_o
);

  logic          v1_q, v2_q;
  logic [W-1:0]  q1_q   [cvd_pkg::LANES];
  logic [W-1:0]  raw1_q [cvd_pkg::LANES];
  cvd_pkg::ctl_t ctl1_q;
  logic [W-1:0]  lim1_q, lim2_q;
  logic [1:0]    left_d, left1_q;
  logic [W+1:0]  newsum;
  logic [1:0]    inc [cvd_pkg::NUC];
  logic [W-1:0]  out_d [cvd_pkg::LANES];
  logic [W-1:0]  out2_q [cvd_pkg::LANES];
  logic          scaled2_q;

  assign newsum = {2'b00, q_i[0]} + {2'b00, q_i[1]} + {2'b00, q_i[2]} + {2'b00, q_i[3]};
  assign left_d = 2'({2'b00, lim_i} - newsum);

  always_comb begin
    for (int i = 0; i < cvd_pkg::NUC; i++) inc[i] = 2'd0;
    unique case (left1_q)
      2'd1: begin
        inc[ctl1_q.ord0] = 2'd1;
      end
      2'd2: begin
        if (ctl1_q.gt34) begin
          inc[ctl1_q.ord0] = 2'd2;
        end else begin
          inc[ctl1_q.ord0] = 2'd1;
          inc[ctl1_q.ord1] = 2'd1;
        end
      end
      2'd3: begin
        inc[ctl1_q.ord0] = 2'd1;
        if (ctl1_q.gt12) inc[ctl1_q.ord0] = inc[ctl1_q.ord0] + 2'd1;
        else inc[ctl1_q.ord1] = inc[ctl1_q.ord1] + 2'd1;
        if (ctl1_q.gt56a) inc[ctl1_q.ord0] = inc[ctl1_q.ord0] + 2'd1;
        else if (ctl1_q.gt56b) inc[ctl1_q.ord1] = inc[ctl1_q.ord1] + 2'd1;
        else inc[ctl1_q.ord2] = inc[ctl1_q.ord2] + 2'd1;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < cvd_pkg::LANES; i++) begin
      if (!ctl1_q.scaled) out_d[i] = raw1_q[i];
      else if (i < cvd_pkg::NUC) out_d[i] = q1_q[i] + W'(inc[i]);
      else out_d[i] = q1_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q      <= q_i;
    raw1_q    <= raw_i;
    ctl1_q    <= ctl_i;
    lim1_q    <= lim_i;
    left1_q   <= left_d;
    out2_q    <= out_d;
    scaled2_q <= ctl1_q.scaled;
    lim2_q    <= lim1_q;
  end

  assign v_o      = v2_q;
  assign out_o    = out2_q;
  assign scaled_o = scaled2_q;
  assign lim_o    = lim2_q;

endmodule

### sv/count_vector_downscale.sv
// count_vector_downscale: top level, config register, divider pipeline
// depends on cvd_pkg, cvd_front, cvd_div_stage, cvd_finish
//
// Scales a record of six base counts so the four nucleotide counts sum to
// the coverage target when they exceed it. A beat is taken on every cycle
// with start high (busy is always low), and its result appears on the output
// ports with done_o high after three front stages (sum, partial products and
// ranking, products and thresholds), one restoring division step per
// quotient bit, and two stages for leftover units and the output register.
// The receiver cannot stall; each result is shown for one cycle.
module count_vector_downscale #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [COUNT_WIDTH-1:0] count_a_i,
  input  logic [COUNT_WIDTH-1:0] count_c_i,
  input  logic [COUNT_WIDTH-1:0] count_g_i,
  input  logic [COUNT_WIDTH-1:0] count_t_i,
  input  logic [COUNT_WIDTH-1:0] count_n_i,
  input  logic [COUNT_WIDTH-1:0] count_del_i,
  output logic                   done_o,
  output logic [COUNT_WIDTH-1:0] out_a_o,
  output logic [COUNT_WIDTH-1:0] out_c_o,
  output logic [COUNT_WIDTH-1:0] out_g_o,
  output logic [COUNT_WIDTH-1:0] out_t_o,
  output logic [COUNT_WIDTH-1:0] out_n_o,
  output logic [COUNT_WIDTH-1:0] out_del_o,
  output logic                   was_scaled_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [((COUNT_WIDTH > 32) ? 4 : 3)-1:0]  paddr,
  input  logic [((COUNT_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COUNT_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned W   = COUNT_WIDTH;
  localparam int unsigned AW  = (W > 32) ? 4 : 3;
  localparam int unsigned DW  = (W > 32) ? 64 : 32;
  localparam int unsigned LAT = W + 5;

  logic [W-1:0] lim_q, lim_d;
  logic         wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && (paddr[AW-1] == 1'b0);
  assign lim_d  = wr_en ? pwdata[W-1:0] : lim_q;
  assign prdata = (paddr[AW-1] == 1'b0) ? DW'(lim_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= '1;
    end else begin
      lim_q <= lim_d;
    end
  end

  logic          in_v;
  logic [W-1:0]  cnt [cvd_pkg::LANES];

  assign in_v   = start && !busy;
  assign cnt[0] = count_a_i;
  assign cnt[1] = count_c_i;
  assign cnt[2] = count_g_i;
  assign cnt[3] = count_t_i;
  assign cnt[4] = count_n_i;
  assign cnt[5] = count_del_i;

  logic          v_s   [W+1];
  logic [W+1:0]  rem_s [W+1][cvd_pkg::LANES];
  logic [W-1:0]  lo_s  [W+1][cvd_pkg::LANES];
  logic [W+1:0]  sum_s [W+1];
  logic [W-1:0]  lim_s [W+1];
  logic [W-1:0]  raw_s [W+1][cvd_pkg::LANES];
  cvd_pkg::ctl_t ctl_s [W+1];

  cvd_front #(.W(W)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (in_v),
    .cnt_i  (cnt),
    .lim_i  (lim_q),
    .v_o    (v_s[0]),
    .rem_o  (rem_s[0]),
    .lo_o   (lo_s[0]),
    .sum_o  (sum_s[0]),
    .lim_o  (lim_s[0]),
    .raw_o  (raw_s[0]),
    .ctl_o  (ctl_s[0])
  );

  for (genvar k = 0; k < W; k++) begin : g_div
    cvd_div_stage #(.W(W)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .v_i    (v_s[k]),
      .rem_i  (rem_s[k]),
      .lo_i   (lo_s[k]),
      .sum_i  (sum_s[k]),
      .lim_i  (lim_s[k]),
      .raw_i  (raw_s[k]),
      .ctl_i  (ctl_s[k]),
      .v_o    (v_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .lo_o   (lo_s[k+1]),
      .sum_o  (sum_s[k+1]),
      .lim_o  (lim_s[k+1]),
      .raw_o  (raw_s[k+1]),
      .ctl_o  (ctl_s[k+1])
    );
  end

  logic [W-1:0] res [cvd_pkg::LANES];
  logic [W-1:0] fin_lim;

  cvd_finish #(.W(W)) u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .v_i      (v_s[W]),
    .q_i      (lo_s[W]),
    .lim_i    (lim_s[W]),
    .raw_i    (raw_s[W]),
    .ctl_i    (ctl_s[W]),
    .v_o      (done_o),
    .out_o    (res),
    .scaled_o (was_scaled_o),
    .lim_o    (fin_lim)
  );

  assign out_a_o   = res[0];
  assign out_c_o   = res[1];
  assign out_g_o   = res[2];
  assign out_t_o   = res[3];
  assign out_n_o   = res[4];
  assign out_del_o = res[5];

  // a result only follows an accepted beat that passed through the whole pipeline
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LAT))
    else $error("result without matching start");

  // scaled nucleotide counts add up exactly to the target
  a_scaled_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && was_scaled_o) |->
      (({2'b00, out_a_o} + {2'b00, out_c_o} + {2'b00, out_g_o} + {2'b00, out_t_o})
       == {2'b00, fin_lim}))
    else $error("scaled sum differs from target");

  // unscaled results pass the counts through and never exceed the target
  a_unscaled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !was_scaled_o) |->
      (({2'b00, out_a_o} + {2'b00, out_c_o} + {2'b00, out_g_o} + {2'b00, out_t_o})
       <= {2'b00, fin_lim}))
    else $error("unscaled sum above target");

endmodule
